@@ rtl/i32fa_pkg.sv @@
`timescale 1ns / 1ps
package i32fa_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned OpBits   = 4;

  typedef enum logic [OpBits-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_SHL  = 4'd5,
    OP_ASHR = 4'd6,
    OP_AND  = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_SGT  = 4'd10,
    OP_SGE  = 4'd11,
    OP_SLT  = 4'd12,
    OP_SLE  = 4'd13
  } op_t;

  localparam logic [WordBits-1:0] SignBit = 32'h8000_0000;
  localparam logic [WordBits-1:0] AllOnes = 32'hFFFF_FFFF;

  // Information that rides alongside the divider through every stage.
  typedef struct packed {
    logic                is_div;
    logic                is_mod;
    logic                qneg;
    logic                rneg;
    logic                ok;
    logic [WordBits-1:0] res;
  } side_t;

endpackage

@@ rtl/i32fa_ifs.sv @@
`timescale 1ns / 1ps
interface i32fa_req_if;
  logic                                valid;
  logic                                ready;
  logic [i32fa_pkg::OpBits-1:0]        operation;
  logic signed [i32fa_pkg::WordBits-1:0] operand_a;
  logic signed [i32fa_pkg::WordBits-1:0] operand_b;
  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface i32fa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [i32fa_pkg::WordBits-1:0] result_value;
  logic                                folded;
  modport source (output valid, result_value, folded, input ready);
  modport sink (input valid, result_value, folded, output ready);
endinterface

@@ rtl/i32fa_div_step.sv @@
`timescale 1ns / 1ps
// One radix-2 restoring division step with its pipeline register.
module i32fa_div_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_i,
  input  i32fa_pkg::side_t                  side_i,
  input  logic [i32fa_pkg::WordBits-1:0]    rem_i,
  input  logic [i32fa_pkg::WordBits-1:0]    quo_i,
  input  logic [i32fa_pkg::WordBits-1:0]    div_i,
  output logic                              valid_o,
  output i32fa_pkg::side_t                  side_o,
  output logic [i32fa_pkg::WordBits-1:0]    rem_o,
  output logic [i32fa_pkg::WordBits-1:0]    quo_o,
  output logic [i32fa_pkg::WordBits-1:0]    div_o
);
  logic [i32fa_pkg::WordBits:0]   shifted;
  logic [i32fa_pkg::WordBits:0]   diff;
  logic                           take;

  assign shifted = {rem_i, quo_i[i32fa_pkg::WordBits-1]};
  assign diff    = shifted - {1'b0, div_i};
  assign take    = ~diff[i32fa_pkg::WordBits];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      div_o  <= div_i;
      rem_o  <= take ? diff[i32fa_pkg::WordBits-1:0] : shifted[i32fa_pkg::WordBits-1:0];
      quo_o  <= {quo_i[i32fa_pkg::WordBits-2:0], take};
    end
  end
endmodule

@@ rtl/int32_fold_alu_unit.sv @@
`timescale 1ns / 1ps
// Pipelined 32-bit integer ALU that folds one operation on two signed operands
// per transaction: wrapping add, sub and mul, truncating signed divide and
// remainder, shift left, arithmetic shift right, bitwise and, and six signed
// compares. It accepts a new transaction in every cycle that the output
// register is empty or being drained, and it has one decode stage (which
// also holds the multiplier and the simple operations), 32 restoring divider
// stages that each retire one quotient bit, and one sign-fixing output stage.
// The divider depth sets the latency. The whole pipeline advances together
// whenever the output register is empty or being drained, so a stall holds
// every item in place. The folded flag is low, with a zero result, for a zero
// divisor, for the most negative value divided by minus one, for a shift
// amount outside 0 to 31, and for unknown operation codes.
module int32_fold_alu_unit (
  input  logic      clk,
  input  logic      rst,
  i32fa_req_if.sink req,
  i32fa_rsp_if.source rsp
);
  localparam int unsigned W = i32fa_pkg::WordBits;

  logic en;

  // The output register is the last stage; everything moves when it can drain.
  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  // Decode stage.
  logic [W-1:0]     a;
  logic [W-1:0]     b;
  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;
  logic [W-1:0]     mul_lo;
  i32fa_pkg::side_t dec_side;
  i32fa_pkg::op_t   op;
  logic             shift_ok;
  logic             div_bad;
  logic             slt;
  logic             sgt;

  assign a        = req.operand_a;
  assign b        = req.operand_b;
  assign op       = i32fa_pkg::op_t'(req.operation);
  assign mag_a    = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b    = b[W-1] ? (~b + 1'b1) : b;
  assign mul_lo   = W'(a * b);
  assign shift_ok = (b[W-1:5] == '0);
  assign div_bad  = (b == '0) || (a == i32fa_pkg::SignBit && b == i32fa_pkg::AllOnes);
  assign slt      = $signed(a) < $signed(b);
  assign sgt      = $signed(b) < $signed(a);

  always_comb begin
    dec_side.is_div = 1'b0;
    dec_side.is_mod = 1'b0;
    dec_side.qneg   = a[W-1] ^ b[W-1];
    dec_side.rneg   = a[W-1];
    dec_side.ok     = 1'b1;
    dec_side.res    = '0;
    unique case (op)
      i32fa_pkg::OP_ADD:  dec_side.res = a + b;
      i32fa_pkg::OP_SUB:  dec_side.res = a - b;
      i32fa_pkg::OP_MUL:  dec_side.res = mul_lo;
      i32fa_pkg::OP_DIV: begin
        dec_side.is_div = 1'b1;
        dec_side.ok     = ~div_bad;
      end
      i32fa_pkg::OP_MOD: begin
        dec_side.is_mod = 1'b1;
        dec_side.ok     = ~div_bad;
      end
      i32fa_pkg::OP_SHL: begin
        dec_side.ok  = shift_ok;
        dec_side.res = a << b[4:0];
      end
      i32fa_pkg::OP_ASHR: begin
        dec_side.ok  = shift_ok;
        dec_side.res = $signed(a) >>> b[4:0];
      end
      i32fa_pkg::OP_AND:  dec_side.res = a & b;
      i32fa_pkg::OP_EQ:   dec_side.res = W'(a == b);
      i32fa_pkg::OP_NE:   dec_side.res = W'(a != b);
      i32fa_pkg::OP_SGT:  dec_side.res = {{(W-1){1'b0}}, sgt};
      i32fa_pkg::OP_SGE:  dec_side.res = {{(W-1){1'b0}}, ~slt};
      i32fa_pkg::OP_SLT:  dec_side.res = {{(W-1){1'b0}}, slt};
      i32fa_pkg::OP_SLE:  dec_side.res = {{(W-1){1'b0}}, ~sgt};
      default:            dec_side.ok  = 1'b0;
    endcase
    if (!dec_side.ok) begin
      dec_side.res = '0;
    end
  end

  // Stage arrays; index 0 is the decode register, index W the last divider stage.
  logic             valid_s [W+1];
  i32fa_pkg::side_t side_s  [W+1];
  logic [W-1:0]     rem_s   [W+1];
  logic [W-1:0]     quo_s   [W+1];
  logic [W-1:0]     div_s   [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (en) begin
      valid_s[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0] <= dec_side;
      rem_s[0]  <= '0;
      quo_s[0]  <= mag_a;
      div_s[0]  <= mag_b;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_div
    i32fa_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (valid_s[i]),
      .side_i  (side_s[i]),
      .rem_i   (rem_s[i]),
      .quo_i   (quo_s[i]),
      .div_i   (div_s[i]),
      .valid_o (valid_s[i+1]),
      .side_o  (side_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .div_o   (div_s[i+1])
    );
  end

  // Output stage: apply the signs to quotient and remainder.
  logic [W-1:0]     result_next;
  i32fa_pkg::side_t last;
  logic [W-1:0]     q;
  logic [W-1:0]     r;

  assign last = side_s[W];
  assign q    = quo_s[W];
  assign r    = rem_s[W];

  always_comb begin
    priority if (!last.ok) begin
      result_next = '0;
    end else if (last.is_div) begin
      result_next = last.qneg ? (~q + 1'b1) : q;
    end else if (last.is_mod) begin
      result_next = last.rneg ? (~r + 1'b1) : r;
    end else begin
      result_next = last.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= valid_s[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result_value <= result_next;
      rsp.folded       <= last.ok;
    end
  end
endmodule
